// ----- hdl/cdq_pkg.sv -----
// Shared constants, codes and control structs for the circular deque edit unit.
// Used by the interfaces, the controller, the datapath and the top level.
package cdq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 9;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic start;
    logic run;
    logic final_op;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic moving;
  } dp_stat_t;

endpackage

// ----- hdl/cdq_in_if.sv -----
// Input channel of the circular deque edit unit: one edit command per beat.
// Depends on cdq_pkg for the field widths.
interface cdq_in_if;
  logic                       valid;
  logic                       ready;
  logic [cdq_pkg::CmdW-1:0]   cmd;
  logic [cdq_pkg::PosW-1:0]   position;
  logic [cdq_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, output cmd, output position, output byte_in, input ready);
  modport sink   (input valid, input cmd, input position, input byte_in, output ready);
endinterface

// ----- hdl/cdq_out_if.sv -----
// Output channel of the circular deque edit unit: one result per beat.
// Depends on cdq_pkg for the field widths.
interface cdq_out_if;
  logic                         valid;
  logic                         ready;
  logic [cdq_pkg::ByteW-1:0]    byte_out;
  logic [cdq_pkg::CountW-1:0]   length_out;
  logic [cdq_pkg::StatusW-1:0]  status;

  modport source (output valid, output byte_out, output length_out, output status, input ready);
  modport sink   (input valid, input byte_out, input length_out, input status, output ready);
endinterface

// ----- hdl/cdq_ctrl.sv -----
// Controller state machine of the circular deque edit unit.
// Sequences accept, shift, final access and result hand-off; uses cdq_pkg.
module cdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cdq_pkg::dp_stat_t   stat_i,
  output cdq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOVE  = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_WB    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd_o.run = 1'b1;
        if (!stat_i.moving) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.final_op = 1'b1;
        state_d        = ST_WB;
      end
      ST_WB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/cdq_dp.sv -----
// Datapath of the circular deque edit unit: byte store, head and count,
// shift pointers and result registers. Driven by cdq_ctrl; uses cdq_pkg.
module cdq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::ctrl_cmd_t            cmd_i,
  output cdq_pkg::dp_stat_t             stat_o,
  input  logic [cdq_pkg::CmdW-1:0]      in_cmd_i,
  input  logic [cdq_pkg::PosW-1:0]      in_position_i,
  input  logic [cdq_pkg::ByteW-1:0]     in_byte_i,
  output logic [cdq_pkg::ByteW-1:0]     byte_out_o,
  output logic [cdq_pkg::CountW-1:0]    length_out_o,
  output logic [cdq_pkg::StatusW-1:0]   status_o
);

  localparam int unsigned AW = cdq_pkg::AddrW;
  localparam int unsigned CW = cdq_pkg::CountW;
  localparam int unsigned BW = cdq_pkg::ByteW;

  logic [BW-1:0] mem_q [cdq_pkg::Capacity];
  logic [BW-1:0] rdata_q;

  logic [AW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] n_q;
  logic [AW-1:0] src_q, dst_q, fin_addr_q;
  logic          up_q, pend_q, fin_we_q, fin_re_q;
  logic [BW-1:0] byte_q;
  cdq_pkg::status_e st_q;

  logic [BW-1:0] byte_out_q;
  logic [CW-1:0] length_q;
  logic [cdq_pkg::StatusW-1:0] status_q;

  logic [AW-1:0] p_head, p_src, p_addr;
  logic [CW-1:0] p_count, p_n, half, q;
  logic          p_up, p_we, p_re, full;
  cdq_pkg::status_e p_status;
  logic [AW-1:0] pos8, c8, q8;

  logic          issue, mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [BW-1:0] wdata;

  assign full = (count_q == CW'(cdq_pkg::Capacity));
  assign half = count_q >> 1;
  assign pos8 = in_position_i[AW-1:0];
  assign c8   = count_q[AW-1:0];
  assign q    = (CW'(in_position_i) >= count_q) ? count_q - CW'(1) : CW'(in_position_i);
  assign q8   = q[AW-1:0];

  always_comb begin
    p_head   = head_q;
    p_count  = count_q;
    p_n      = '0;
    p_src    = head_q;
    p_up     = 1'b1;
    p_addr   = head_q;
    p_we     = 1'b0;
    p_re     = 1'b0;
    p_status = cdq_pkg::STATUS_OK;
    unique case (in_cmd_i)
      cdq_pkg::CMD_APPEND: begin
        if (full) begin
          p_status = cdq_pkg::STATUS_FULL;
        end else begin
          p_we    = 1'b1;
          p_addr  = head_q + c8;
          p_count = count_q + CW'(1);
        end
      end
      cdq_pkg::CMD_PREPEND: begin
        if (full) begin
          p_status = cdq_pkg::STATUS_FULL;
        end else begin
          p_we    = 1'b1;
          p_head  = head_q - AW'(1);
          p_addr  = head_q - AW'(1);
          p_count = count_q + CW'(1);
        end
      end
      cdq_pkg::CMD_INSERT: begin
        if (full) begin
          p_status = cdq_pkg::STATUS_FULL;
        end else begin
          p_we    = 1'b1;
          p_count = count_q + CW'(1);
          if (in_position_i == '0) begin
            p_head = head_q - AW'(1);
            p_addr = head_q - AW'(1);
          end else if (CW'(in_position_i) >= count_q) begin
            p_addr = head_q + c8;
          end else if (CW'(in_position_i) <= half) begin
            p_n    = CW'(in_position_i);
            p_src  = head_q;
            p_up   = 1'b1;
            p_addr = head_q + pos8 - AW'(1);
            p_head = head_q - AW'(1);
          end else begin
            p_n    = count_q - CW'(in_position_i);
            p_src  = head_q + c8 - AW'(1);
            p_up   = 1'b0;
            p_addr = head_q + pos8;
          end
        end
      end
      cdq_pkg::CMD_DELETE: begin
        if (count_q == '0) begin
          p_status = cdq_pkg::STATUS_EMPTY;
        end else begin
          p_count = count_q - CW'(1);
          if (q >= count_q - CW'(1)) begin
            p_n = '0;
          end else if (q == '0) begin
            p_head = head_q + AW'(1);
          end else if (q < half) begin
            p_n    = q;
            p_src  = head_q + q8 - AW'(1);
            p_up   = 1'b0;
            p_head = head_q + AW'(1);
          end else begin
            p_n   = count_q - CW'(1) - q;
            p_src = head_q + q8 + AW'(1);
            p_up  = 1'b1;
          end
        end
      end
      cdq_pkg::CMD_READ: begin
        if (CW'(in_position_i) >= count_q) begin
          p_status = cdq_pkg::STATUS_RANGE;
        end else begin
          p_re   = 1'b1;
          p_addr = head_q + pos8;
        end
      end
      default: begin
        p_status = cdq_pkg::STATUS_OK;
      end
    endcase
  end

  assign issue = cmd_i.run && (n_q != '0);

  always_comb begin
    mem_we = 1'b0;
    waddr  = dst_q;
    wdata  = rdata_q;
    if (pend_q) begin
      mem_we = 1'b1;
    end else if (cmd_i.final_op && fin_we_q) begin
      mem_we = 1'b1;
      waddr  = fin_addr_q;
      wdata  = byte_q;
    end
    mem_re = issue || (cmd_i.final_op && fin_re_q);
    raddr  = issue ? src_q : fin_addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      n_q      <= '0;
      pend_q   <= 1'b0;
      fin_we_q <= 1'b0;
      fin_re_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (cmd_i.start) begin
        head_q   <= p_head;
        count_q  <= p_count;
        n_q      <= p_n;
        fin_we_q <= p_we;
        fin_re_q <= p_re;
      end else if (issue) begin
        n_q <= n_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q      <= p_src;
      up_q       <= p_up;
      fin_addr_q <= p_addr;
      byte_q     <= in_byte_i;
      st_q       <= p_status;
    end else if (issue) begin
      src_q <= up_q ? src_q + AW'(1) : src_q - AW'(1);
    end
    if (issue) begin
      dst_q <= up_q ? src_q - AW'(1) : src_q + AW'(1);
    end
    if (cmd_i.load_out) begin
      byte_out_q <= fin_re_q ? rdata_q : '0;
      length_q   <= count_q;
      status_q   <= st_q;
    end
  end

  assign stat_o.moving = (n_q != '0) || pend_q;
  assign byte_out_o    = byte_out_q;
  assign length_out_o  = length_q;
  assign status_o      = status_q;

endmodule

// ----- hdl/circular_deque_with_positional_edit_unit.sv -----
// Circular byte deque with positional insert, delete and read, one command
// per input beat and one result beat per command. An append, prepend, end
// insert, end delete, rejected command or read passes from accept through
// the final store access to the result hand-off; a middle insert or delete
// first shifts bytes one at a time and then finishes the last move. The
// bytes shifted are the shorter side, at most half the capacity less one. The
// shift runs through the single-port-write byte store, one byte per cycle.
// The store needs no clearing after reset.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctrl and cdq_dp.
module circular_deque_with_positional_edit_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  cdq_in_if.sink          in_i,
  cdq_out_if.source       out_o
);

  cdq_pkg::ctrl_cmd_t ctrl_cmd;
  cdq_pkg::dp_stat_t  dp_stat;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  cdq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .stat_o        (dp_stat),
    .in_cmd_i      (in_i.cmd),
    .in_position_i (in_i.position),
    .in_byte_i     (in_i.byte_in),
    .byte_out_o    (out_o.byte_out),
    .length_out_o  (out_o.length_out),
    .status_o      (out_o.status)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for circular_deque_with_positional_edit_unit: a scripted opening, then
// random edit commands checked against a text-buffer predictor held in the bench.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if and the unit itself.
module tb_top;

  typedef logic [cdq_pkg::CmdW-1:0]   cmd_t;
  typedef logic [cdq_pkg::PosW-1:0]   pos_t;
  typedef logic [cdq_pkg::ByteW-1:0]  byte_t;
  typedef logic [cdq_pkg::CountW-1:0] len_t;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PosMax     = (1 << cdq_pkg::PosW) - 1;

  localparam cmd_t CmdSpare5 = 3'd5;
  localparam cmd_t CmdSpare6 = 3'd6;
  localparam cmd_t CmdSpare7 = 3'd7;

  typedef struct packed {
    cmd_t  cmd;
    pos_t  position;
    byte_t byte_in;
  } edit_cmd_t;

  typedef struct packed {
    byte_t             byte_out;
    len_t              length_out;
    cdq_pkg::status_e  status;
  } edit_result_t;

  typedef struct {
    edit_cmd_t    beat;
    bit           typed;
    edit_result_t want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_with_positional_edit_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  byte_t                      text_mem [cdq_pkg::Capacity];
  logic [cdq_pkg::AddrW-1:0]  text_head = '0;
  len_t                       text_len  = '0;

  edit_result_t pending_results [$];
  script_row_t  script_rows [$];

  bit           row_typed = 1'b0;
  edit_result_t row_want  = '0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  bit           hold_request  = 1'b0;
  int unsigned  errors        = 0;
  int unsigned  cmds_accepted = 0;
  int unsigned  results_seen  = 0;
  int unsigned  peak_len      = 0;
  int unsigned  status_tally [4] = '{0, 0, 0, 0};
  int unsigned  cycle_count   = 0;

  function automatic logic [cdq_pkg::AddrW-1:0] phys(input int unsigned idx);
    int unsigned s;
    s = (32'(text_head) + idx) % cdq_pkg::Capacity;
    return s[cdq_pkg::AddrW-1:0];
  endfunction

  function automatic edit_result_t apply_edit(input edit_cmd_t c);
    edit_result_t r;
    int unsigned  n;
    int unsigned  p;
    int unsigned  i;
    n = 32'(text_len);
    p = 32'(c.position);
    r.byte_out = '0;
    r.status   = cdq_pkg::STATUS_OK;
    case (c.cmd)
      cdq_pkg::CMD_APPEND, cdq_pkg::CMD_PREPEND, cdq_pkg::CMD_INSERT: begin
        if (n >= cdq_pkg::Capacity) begin
          r.status = cdq_pkg::STATUS_FULL;
        end else if (c.cmd == cdq_pkg::CMD_PREPEND ||
                     (c.cmd == cdq_pkg::CMD_INSERT && p == 0)) begin
          text_head = phys(cdq_pkg::Capacity - 1);
          text_mem[text_head] = c.byte_in;
          text_len = text_len + len_t'(1);
        end else if (c.cmd == cdq_pkg::CMD_APPEND || p >= n) begin
          text_mem[phys(n)] = c.byte_in;
          text_len = text_len + len_t'(1);
        end else begin
          if (p <= n / 2) begin
            text_head = phys(cdq_pkg::Capacity - 1);
            for (i = 0; i < p; i++) text_mem[phys(i)] = text_mem[phys(i + 1)];
          end else begin
            for (i = n; i > p; i--) text_mem[phys(i)] = text_mem[phys(i - 1)];
          end
          text_mem[phys(p)] = c.byte_in;
          text_len = text_len + len_t'(1);
        end
      end
      cdq_pkg::CMD_DELETE: begin
        if (n == 0) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else begin
          if (p >= n) p = n - 1;
          if (p + 1 >= n) begin
            // The last byte goes without moving anything.
          end else if (p == 0) begin
            text_head = phys(1);
          end else if (p < n / 2) begin
            for (i = p; i > 0; i--) text_mem[phys(i)] = text_mem[phys(i - 1)];
            text_head = phys(1);
          end else begin
            for (i = p; i + 1 < n; i++) text_mem[phys(i)] = text_mem[phys(i + 1)];
          end
          text_len = text_len - len_t'(1);
        end
      end
      cdq_pkg::CMD_READ: begin
        if (p >= n) r.status = cdq_pkg::STATUS_RANGE;
        else r.byte_out = text_mem[phys(p)];
      end
      default: begin
      end
    endcase
    r.length_out = text_len;
    return r;
  endfunction

  function automatic pos_t pick_position(input int unsigned n);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 8) return '0;
    if (r < 18 || n == 0) return pos_t'($urandom_range(PosMax, n));
    return pos_t'($urandom_range(n - 1, 0));
  endfunction

  // Below the goal length most edits grow the text; at or above it most shrink it.
  function automatic edit_cmd_t next_edit(input int unsigned goal);
    edit_cmd_t   c;
    int unsigned r;
    int unsigned n;
    n = 32'(text_len);
    c.byte_in  = byte_t'($urandom_range(255, 0));
    c.position = pick_position(n);
    r = $urandom_range(99, 0);
    if (r < 4) begin
      c.cmd = cmd_t'($urandom_range(32'(CmdSpare7), 32'(CmdSpare5)));
    end else if (r < 10) begin
      c.cmd = cdq_pkg::CMD_READ;
    end else if ($urandom_range(99, 0) < ((n < goal) ? 95 : 20)) begin
      r = $urandom_range(99, 0);
      c.cmd = (r < 20) ? cdq_pkg::CMD_APPEND :
              (r < 40) ? cdq_pkg::CMD_PREPEND : cdq_pkg::CMD_INSERT;
    end else begin
      c.cmd = cdq_pkg::CMD_DELETE;
    end
    return c;
  endfunction

  task automatic add_row(input cmd_t cmd, input pos_t pos,
                         input byte_t data, input bit typed,
                         input int unsigned want_len, input cdq_pkg::status_e want_status);
    script_row_t row;
    row.beat.cmd        = cmd;
    row.beat.position   = pos;
    row.beat.byte_in    = data;
    row.typed           = typed;
    row.want.byte_out   = '0;
    row.want.length_out = len_t'(want_len);
    row.want.status     = want_status;
    script_rows.push_back(row);
  endtask

  task automatic send_edit(input edit_cmd_t c, input bit typed, input edit_result_t want);
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= c.cmd;
    in_if.position <= c.position;
    in_if.byte_in  <= c.byte_in;
    row_typed = typed;
    row_want  = want;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(negedge clk_i) begin : watch
    edit_cmd_t    c;
    edit_result_t got;
    edit_result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        c.cmd      = in_if.cmd;
        c.position = in_if.position;
        c.byte_in  = in_if.byte_in;
        got = apply_edit(c);
        pending_results.push_back(row_typed ? row_want : got);
        cmds_accepted++;
        if (32'(text_len) > peak_len) peak_len = 32'(text_len);
      end
      if (out_if.valid && out_if.ready) begin
        got.byte_out   = out_if.byte_out;
        got.length_out = out_if.length_out;
        got.status     = cdq_pkg::status_e'(out_if.status);
        results_seen++;
        status_tally[got.status]++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat with no command pending, got length %0d status %0d",
                   $time, got.length_out, got.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
          check_field("length_out", 32'(want.length_out), 32'(got.length_out));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    bit          accept_next;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        accept_next = 1'b0;
      end else begin
        accept_next = ($urandom_range(99, 0) >= recv_idle_pct);
      end
      @(posedge clk_i);
      out_if.ready <= accept_next;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("[circular_deque_with_positional_edit_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = '0;
    in_if.position = '0;
    in_if.byte_in  = '0;
    foreach (text_mem[i]) text_mem[i] = '0;

    add_row(cdq_pkg::CMD_READ,    9'h000, 8'h00, 1'b1, 0, cdq_pkg::STATUS_RANGE);
    add_row(cdq_pkg::CMD_DELETE,  9'h000, 8'h00, 1'b1, 0, cdq_pkg::STATUS_EMPTY);
    add_row(CmdSpare5,            9'h1FF, 8'hFF, 1'b1, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_APPEND,  9'h000, 8'h41, 1'b1, 1, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_PREPEND, 9'h000, 8'hFF, 1'b1, 2, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_INSERT,  9'h000, 8'h00, 1'b1, 3, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_INSERT,  9'h1FF, 8'h80, 1'b1, 4, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_INSERT,  9'h002, 8'h55, 1'b1, 5, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_INSERT,  9'h004, 8'hAA, 1'b1, 6, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h000, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h002, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h004, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h005, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h006, 8'h00, 1'b1, 6, cdq_pkg::STATUS_RANGE);
    add_row(cdq_pkg::CMD_READ,    9'h100, 8'h00, 1'b1, 6, cdq_pkg::STATUS_RANGE);
    add_row(CmdSpare6,            9'h000, 8'h00, 1'b1, 6, cdq_pkg::STATUS_OK);
    add_row(CmdSpare7,            9'h0AA, 8'h55, 1'b1, 6, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h001, 8'h00, 1'b1, 5, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h003, 8'h00, 1'b1, 4, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h000, 8'h00, 1'b1, 3, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h1FF, 8'h00, 1'b1, 2, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h000, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_READ,    9'h001, 8'h00, 1'b0, 0, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h000, 8'h00, 1'b1, 1, cdq_pkg::STATUS_OK);
    add_row(cdq_pkg::CMD_DELETE,  9'h001, 8'h00, 1'b1, 0, cdq_pkg::STATUS_OK);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 63;
    foreach (script_rows[i]) send_edit(script_rows[i].beat, script_rows[i].typed,
                                       script_rows[i].want);
    repeat (40) send_edit(next_edit(12), 1'b0, '0);
    repeat (60) send_edit(next_edit(100), 1'b0, '0);
    wait_drained();

    // The receiver holds off while commands keep coming, so the unit backs up.
    send_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (12) send_edit(next_edit(100), 1'b0, '0);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 26;
    repeat (100) send_edit(next_edit(cdq_pkg::Capacity), 1'b0, '0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (32'(text_len) < cdq_pkg::Capacity) begin
      send_edit(next_edit(cdq_pkg::Capacity + 1), 1'b0, '0);
    end
    repeat (25) send_edit(next_edit(cdq_pkg::Capacity + 1), 1'b0, '0);
    repeat (40) send_edit(next_edit(0), 1'b0, '0);
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("Checked %0d results for %0d commands; peak length %0d of %0d.",
             results_seen, cmds_accepted, peak_len, cdq_pkg::Capacity);
    $display("Rejections seen: %0d full, %0d empty, %0d reads out of range.",
             status_tally[cdq_pkg::STATUS_FULL], status_tally[cdq_pkg::STATUS_EMPTY],
             status_tally[cdq_pkg::STATUS_RANGE]);
    if (errors == 0) begin
      $display("[circular_deque_with_positional_edit_unit] OK");
    end else begin
      $display("[circular_deque_with_positional_edit_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- circular_deque_with_positional_edit_unit.f -----
hdl/cdq_pkg.sv
hdl/cdq_in_if.sv
hdl/cdq_out_if.sv
hdl/cdq_ctrl.sv
hdl/cdq_dp.sv
hdl/circular_deque_with_positional_edit_unit.sv
test/tb_top.sv
